@@ rtl/stsum_pkg.sv @@
// Shared definitions for the segment tree range sum block.
// Field widths, defaults, mode codes and the accumulator control struct.
// No dependencies.
package stsum_pkg;

  localparam int LEAVES_DEFAULT = 1024;
  localparam int POS_W          = 10;
  localparam int DELTA_W        = 32;
  localparam int SUM_W          = 64;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Control from the sequencer to the query accumulator.
  typedef struct packed {
    logic clear;   // start of a query: zero the running sum
    logic issue;   // a pair of node reads was issued this cycle
    logic take_l;  // left node of the pair counts toward the sum
    logic take_r;  // right node of the pair counts toward the sum
  } acc_ctrl_t;

endpackage

@@ rtl/segment_tree_range_sum.sv @@
// Top level of the segment tree range sum block: stream ports, output register
// and assertions. Depends on stsum_pkg, stsum_ram, stsum_accum and stsum_seq.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  s_tuser: mode; s_tdata: position, delta,
//                                    range_low, range_high
//   m_*      out  m_tvalid/m_tready  m_tdata: range_sum
//
// Items are handled one at a time; the tree walk through the node RAM sets the
// cost. An add does a leaf read-modify-write, then visits each ancestor in turn,
// reading the sibling and writing the parent.
// A query goes through the accept step, one step per tree level with both range
// ends read at once, a step to see the walk end, a drain of the accumulate
// pipeline and the step that hands the sum over; an empty range skips the walk.
// After reset a clearing pass writes zero to all 2*LEAVES nodes, one a cycle;
// s_tready stays low until the pass is done.
// A result waits in the output register while the next item is taken; only a
// second query that finishes before the first result is taken stalls.
module segment_tree_range_sum #(
  parameter int LEAVES = stsum_pkg::LEAVES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [9:0] position, [41:10] delta, [51:42] range_low, [61:52] range_high,
  // [63:62] zero
  input  logic [63:0] s_tdata,
  // [0] mode
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [63:0] range_sum
  output logic [63:0] m_tdata
);

  localparam int NODES = 2 * LEAVES;
  localparam int NW    = $clog2(NODES);

  logic                        ram_we;
  logic [NW-1:0]               ram_waddr;
  logic [stsum_pkg::SUM_W-1:0] ram_wdata;
  logic [NW-1:0]               ram_raddr_a;
  logic [NW-1:0]               ram_raddr_b;
  logic [stsum_pkg::SUM_W-1:0] ram_rdata_a;
  logic [stsum_pkg::SUM_W-1:0] ram_rdata_b;
  stsum_pkg::acc_ctrl_t        acc_ctrl;
  logic                        acc_busy;
  logic [stsum_pkg::SUM_W-1:0] acc_sum;
  logic                        res_valid;
  logic                        res_ready;

  // The output register is free when empty or emptied in this cycle.
  assign res_ready = !m_tvalid || m_tready;

  stsum_seq #(
    .LEAVES(LEAVES)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .mode        (s_tuser),
    .position    (s_tdata[9:0]),
    .delta       (s_tdata[41:10]),
    .range_low   (s_tdata[51:42]),
    .range_high  (s_tdata[61:52]),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr_a (ram_raddr_a),
    .ram_raddr_b (ram_raddr_b),
    .ram_rdata_a (ram_rdata_a),
    .acc_ctrl    (acc_ctrl),
    .acc_busy    (acc_busy),
    .res_valid   (res_valid),
    .res_ready   (res_ready)
  );

  stsum_ram #(
    .WIDTH(stsum_pkg::SUM_W),
    .DEPTH(NODES)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  stsum_accum u_accum (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (acc_ctrl),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b),
    .sum     (acc_sum),
    .busy    (acc_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (res_valid && res_ready) begin
      m_tdata <= acc_sum;
    end
  end

`ifndef SYNTHESIS
  // The clearing pass follows reset, so no item is taken right after it.
  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !s_tready)
    else $error("input taken during the clearing pass");

  // When a new item can be taken, no query sum is still in flight.
  a_idle_acc_empty: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !acc_busy)
    else $error("accumulator busy while idle");

  // Queries never write the tree.
  a_query_no_write: assert property (@(posedge clk) disable iff (rst)
    acc_ctrl.issue |-> !ram_we)
    else $error("node write during a query walk");

  // The running sum is cleared only when a query transaction is taken.
  a_clear_on_accept: assert property (@(posedge clk) disable iff (rst)
    acc_ctrl.clear |-> (s_tvalid && s_tready && s_tuser == stsum_pkg::MODE_QUERY))
    else $error("accumulator cleared outside a query accept");
`endif

endmodule

@@ rtl/stsum_ram.sv @@
// Generic synchronous RAM: one write port, two registered read ports.
// No dependencies.
module stsum_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ rtl/stsum_accum.sv @@
// Query accumulator: selects the node values read for one level and adds them
// to the running sum over two pipeline stages. Depends on stsum_pkg.
module stsum_accum (
  input  logic                     clk,
  input  logic                     rst,
  input  stsum_pkg::acc_ctrl_t     ctrl,
  input  logic [stsum_pkg::SUM_W-1:0] rdata_a,
  input  logic [stsum_pkg::SUM_W-1:0] rdata_b,
  output logic [stsum_pkg::SUM_W-1:0] sum,
  output logic                     busy
);

  logic                        s1_valid;
  logic                        s1_take_l;
  logic                        s1_take_r;
  logic                        pair_valid;
  logic [stsum_pkg::SUM_W-1:0] pair;
  logic [stsum_pkg::SUM_W-1:0] sel_a;
  logic [stsum_pkg::SUM_W-1:0] sel_b;

  assign sel_a = s1_take_l ? rdata_a : '0;
  assign sel_b = s1_take_r ? rdata_b : '0;
  assign busy  = s1_valid | pair_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      pair_valid <= 1'b0;
    end else begin
      s1_valid   <= ctrl.issue;
      pair_valid <= s1_valid;
    end
    s1_take_l <= ctrl.take_l;
    s1_take_r <= ctrl.take_r;
    pair      <= sel_a + sel_b;
    if (ctrl.clear) begin
      sum <= '0;
    end else if (pair_valid) begin
      sum <= sum + pair;
    end
  end

endmodule

@@ rtl/stsum_seq.sv @@
// Sequencer: clearing pass after reset, leaf-to-root update walk for adds and
// bottom-up pair walk for queries. Drives the node RAM. Depends on stsum_pkg.
module stsum_seq #(
  parameter int LEAVES = stsum_pkg::LEAVES_DEFAULT,
  localparam int NODES = 2 * LEAVES,
  localparam int NW    = $clog2(NODES)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          mode,
  input  logic [stsum_pkg::POS_W-1:0]   position,
  input  logic [stsum_pkg::DELTA_W-1:0] delta,
  input  logic [stsum_pkg::POS_W-1:0]   range_low,
  input  logic [stsum_pkg::POS_W-1:0]   range_high,
  output logic                          ram_we,
  output logic [NW-1:0]                 ram_waddr,
  output logic [stsum_pkg::SUM_W-1:0]   ram_wdata,
  output logic [NW-1:0]                 ram_raddr_a,
  output logic [NW-1:0]                 ram_raddr_b,
  input  logic [stsum_pkg::SUM_W-1:0]   ram_rdata_a,
  output stsum_pkg::acc_ctrl_t          acc_ctrl,
  input  logic                          acc_busy,
  output logic                          res_valid,
  input  logic                          res_ready
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD_LEAF,
    S_ADD_UP,
    S_Q_LOOP,
    S_Q_DRAIN,
    S_Q_RESULT
  } state_t;

  state_t                      state;
  logic [NW-1:0]               clr_addr;
  logic [NW-1:0]               node;
  logic [stsum_pkg::SUM_W-1:0] cur;
  logic [stsum_pkg::SUM_W-1:0] delta_ext;
  logic [NW-1:0]               l;
  logic [NW-1:0]               r;

  logic                        accept;
  logic [31:0]                 pos32;
  logic [31:0]                 lo32;
  logic [31:0]                 hi32;
  logic [31:0]                 hi_clamp;
  logic [NW-1:0]               leaf_node;
  logic [NW-1:0]               parent;
  logic [stsum_pkg::SUM_W-1:0] add_sum;
  logic                        take_l;
  logic                        take_r;
  logic                        more;
  logic [NW:0]                 l_inc;
  logic [NW-1:0]               r_dec;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state == S_Q_RESULT);

  assign pos32     = 32'(position);
  assign lo32      = 32'(range_low);
  assign hi32      = 32'(range_high);
  assign hi_clamp  = (hi32 >= 32'(LEAVES)) ? 32'(LEAVES) - 32'd1 : hi32;
  assign leaf_node = NW'(pos32 + 32'(LEAVES));
  assign parent    = node >> 1;

  // One adder serves both the leaf update and every ancestor recompute.
  assign add_sum = ram_rdata_a + ((state == S_ADD_LEAF) ? delta_ext : cur);

  assign more   = (l <= r);
  assign take_l = l[0];
  assign take_r = ~r[0];
  assign l_inc  = {1'b0, l} + {{NW{1'b0}}, take_l};
  assign r_dec  = r - {{(NW-1){1'b0}}, take_r};

  always_comb begin
    ram_we       = 1'b0;
    ram_waddr    = node;
    ram_wdata    = add_sum;
    ram_raddr_a  = l;
    ram_raddr_b  = r;
    acc_ctrl     = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_IDLE: begin
        ram_raddr_a    = leaf_node;
        acc_ctrl.clear = accept && (mode == stsum_pkg::MODE_QUERY);
      end
      S_ADD_LEAF: begin
        ram_we      = 1'b1;
        ram_raddr_a = node ^ NW'(1);
      end
      S_ADD_UP: begin
        ram_we      = 1'b1;
        ram_waddr   = parent;
        ram_raddr_a = parent ^ NW'(1);
      end
      S_Q_LOOP: begin
        acc_ctrl.issue  = more;
        acc_ctrl.take_l = more && take_l;
        acc_ctrl.take_r = more && take_r;
      end
      S_Q_DRAIN, S_Q_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + NW'(1);
          if (clr_addr == NW'(NODES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (mode == stsum_pkg::MODE_ADD) begin
              // A leaf past the end of the tree takes no update.
              if (pos32 < 32'(LEAVES)) begin
                node      <= leaf_node;
                delta_ext <= {{(stsum_pkg::SUM_W - stsum_pkg::DELTA_W){delta[
                              stsum_pkg::DELTA_W-1]}}, delta};
                state     <= S_ADD_LEAF;
              end
            end else begin
              l <= NW'(lo32 + 32'(LEAVES));
              r <= NW'(hi_clamp + 32'(LEAVES));
              // An empty range skips the walk and reports the cleared sum.
              state <= (lo32 > hi_clamp) ? S_Q_DRAIN : S_Q_LOOP;
            end
          end
        end
        S_ADD_LEAF: begin
          cur   <= add_sum;
          state <= S_ADD_UP;
        end
        S_ADD_UP: begin
          cur  <= add_sum;
          node <= parent;
          if (parent == NW'(1)) begin
            state <= S_IDLE;
          end
        end
        S_Q_LOOP: begin
          if (more) begin
            l <= l_inc[NW:1];
            r <= {1'b0, r_dec[NW-1:1]};
          end else begin
            state <= S_Q_DRAIN;
          end
        end
        S_Q_DRAIN: begin
          if (!acc_busy) begin
            state <= S_Q_RESULT;
          end
        end
        S_Q_RESULT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for segment_tree_range_sum: point adds and range-sum queries
// over the stream ports, checked against a tree model kept inside a scoreboard class.
// Depends on stsum_pkg and the segment_tree_range_sum RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int LEAVES       = stsum_pkg::LEAVES_DEFAULT;
  localparam int RANDOM_ITEMS = 1930;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 400_000;

  typedef logic [stsum_pkg::POS_W-1:0]   pos_t;
  typedef logic [stsum_pkg::DELTA_W-1:0] delta_t;
  typedef bit   [stsum_pkg::SUM_W-1:0]   sum_t;

  // Scoreboard: mirrors the node sums of the tree and queues the sum each query must return.
  class range_sum_board;
    sum_t node_sums [2*LEAVES];
    sum_t pending_sums [$];
    int errors;
    int n_adds;
    int n_queries;
    int n_empty;
    int n_checked;

    function new();
      foreach (node_sums[i]) node_sums[i] = '0;
    endfunction

    // Adds a sign-extended amount to one leaf and rebuilds its ancestors up to the root.
    function void bump_leaf(int unsigned leaf, sum_t amount);
      int unsigned node;
      if (leaf >= LEAVES) return;
      node = LEAVES + leaf;
      node_sums[node] += amount;
      while (node > 1) begin
        node = node >> 1;
        node_sums[node] = node_sums[2*node] + node_sums[2*node+1];
      end
    endfunction

    // Bottom-up walk that collects the covering nodes of leaves first..last.
    function sum_t sum_span(int unsigned first, int unsigned last);
      sum_t total;
      int unsigned l;
      int unsigned r;
      total = '0;
      if (last >= LEAVES) last = LEAVES - 1;
      if (first > last) return '0;
      l = first + LEAVES;
      r = last + LEAVES;
      while (l <= r) begin
        if ((l & 1) != 0) begin
          total += node_sums[l];
          l++;
        end
        if ((r & 1) == 0) begin
          total += node_sums[r];
          r--;
        end
        l = l >> 1;
        r = r >> 1;
      end
      return total;
    endfunction

    function void note_item(bit mode, pos_t pos, delta_t delta, pos_t lo, pos_t hi);
      if (mode == stsum_pkg::MODE_ADD) begin
        n_adds++;
        bump_leaf(int'(pos), {{(stsum_pkg::SUM_W-stsum_pkg::DELTA_W){
                  delta[stsum_pkg::DELTA_W-1]}}, delta});
      end else begin
        n_queries++;
        if (lo > hi) n_empty++;
        pending_sums.push_back(sum_span(int'(lo), int'(hi)));
      end
    endfunction

    function void check_sum(logic [stsum_pkg::SUM_W-1:0] actual);
      sum_t want;
      if (pending_sums.size() == 0) begin
        $error("range_sum: expected no result, actual %0d", $signed(actual));
        errors++;
        return;
      end
      want = pending_sums.pop_front();
      n_checked++;
      if (actual !== want) begin
        $error("range_sum: expected %0d, actual %0d", $signed(want), $signed(actual));
        errors++;
      end
    endfunction

    function int pending();
      return pending_sums.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;

  range_sum_board board;
  bit send_gaps    = 1'b1;
  bit recv_stalls  = 1'b1;
  bit hold_off_req = 1'b0;
  int cycle_count  = 0;

  segment_tree_range_sum #(
    .LEAVES(LEAVES)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Results are taken at the rising edge; the watchdog counts the same edges.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && m_tvalid && m_tready) board.check_sum(m_tdata);
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run timed out after %0d cycles with %0d results outstanding.",
               cycle_count, board.pending());
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off so that a waiting result backs up
  // the block and its input stalls while the sender keeps offering transactions.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_tready <= !(recv_stalls && $urandom_range(99) < 7);
    end
  end

  // Offers one transaction and returns at the falling edge after it was accepted.
  // tvalid stays high into the next call unless that call starts with a gap.
  task automatic send_item(input logic mode, input pos_t pos, input delta_t delta,
                           input pos_t lo, input pos_t hi);
    while (send_gaps && $urandom_range(99) < 7) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {2'b00, hi, lo, delta, pos};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_item(mode, pos, delta, lo, hi);
    @(negedge clk);
  endtask

  // Withdraws the offer so that no transaction is taken twice, then waits until
  // every expected sum has come out.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (board.pending() != 0) @(negedge clk);
  endtask

  initial begin
    int     idx;
    int     first;
    int     last;
    logic   mode;
    pos_t   pos;
    delta_t delta;

    board    = new();
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tuser  = stsum_pkg::MODE_ADD;
    s_tdata  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: extreme leaves and deltas, ignored fields carrying values,
    // empty ranges, single leaves, the full range and a zero delta.
    send_item(stsum_pkg::MODE_QUERY, 10'd0,    32'h0,        10'd0,    10'd1023);
    send_item(stsum_pkg::MODE_ADD,   10'd0,    32'h7FFFFFFF, 10'd1023, 10'd1023);
    send_item(stsum_pkg::MODE_ADD,   10'd1023, 32'h80000000, 10'd0,    10'd0);
    send_item(stsum_pkg::MODE_ADD,   10'd512,  32'hFFFFFFFF, 10'd0,    10'd0);
    send_item(stsum_pkg::MODE_ADD,   10'd511,  32'h00000001, 10'd0,    10'd0);
    send_item(stsum_pkg::MODE_ADD,   10'd0,    32'h7FFFFFFF, 10'd0,    10'd0);
    send_item(stsum_pkg::MODE_QUERY, 10'd0,    32'h0,        10'd0,    10'd0);
    send_item(stsum_pkg::MODE_QUERY, 10'd0,    32'h0,        10'd1023, 10'd1023);
    send_item(stsum_pkg::MODE_QUERY, 10'd0,    32'h0,        10'd0,    10'd1023);
    send_item(stsum_pkg::MODE_QUERY, 10'd0,    32'h0,        10'd511,  10'd512);
    send_item(stsum_pkg::MODE_QUERY, 10'd0,    32'h0,        10'd1,    10'd1022);
    send_item(stsum_pkg::MODE_QUERY, 10'd0,    32'h0,        10'd5,    10'd3);
    send_item(stsum_pkg::MODE_QUERY, 10'd0,    32'h0,        10'd1023, 10'd0);
    send_item(stsum_pkg::MODE_QUERY, 10'd1023, 32'hFFFFFFFF, 10'd0,    10'd511);
    send_item(stsum_pkg::MODE_QUERY, 10'd0,    32'h0,        10'd512,  10'd1023);
    send_item(stsum_pkg::MODE_ADD,   10'd1023, 32'h80000000, 10'd0,    10'd0);
    send_item(stsum_pkg::MODE_QUERY, 10'd0,    32'h0,        10'd1000, 10'd1023);
    send_item(stsum_pkg::MODE_ADD,   10'd300,  32'h0,        10'd0,    10'd0);
    send_item(stsum_pkg::MODE_QUERY, 10'd0,    32'h0,        10'd300,  10'd300);

    // Random part. Adds land mostly in a few hot spots so that queries see sums that
    // are not trivially zero; query ranges are a mix of wide, narrow and empty.
    for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
      if (idx == 500) begin
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
      end
      if (idx == 800) begin
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
      end
      if (idx == 1000) hold_off_req = 1'b1;
      if (idx == 1400) wait_for_results();

      mode = ($urandom_range(99) < 55) ? stsum_pkg::MODE_ADD : stsum_pkg::MODE_QUERY;
      case ($urandom_range(3))
        0:       pos = pos_t'($urandom_range(15));
        1:       pos = pos_t'(LEAVES - 1 - $urandom_range(15));
        2:       pos = pos_t'(500 + $urandom_range(31));
        default: pos = pos_t'($urandom_range(LEAVES - 1));
      endcase
      case ($urandom_range(3))
        0:       delta = delta_t'($urandom_range(200) - 100);
        1:       delta = $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
        default: delta = $urandom;
      endcase
      first = $urandom_range(LEAVES - 1);
      case ($urandom_range(3))
        0:       last = $urandom_range(LEAVES - 1);
        1:       last = (first + $urandom_range(7) > LEAVES - 1) ? LEAVES - 1
                                                                : first + $urandom_range(7);
        2: begin
          first = $urandom_range(LEAVES - 1, 1);
          last  = $urandom_range(first - 1);
        end
        default: begin
          first = $urandom_range(1) ? 0 : first;
          last  = (first == 0) ? $urandom_range(LEAVES - 1) : LEAVES - 1;
        end
      endcase
      send_item(mode, pos, delta, first[stsum_pkg::POS_W-1:0], last[stsum_pkg::POS_W-1:0]);
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d adds and %0d queries (%0d with an empty range); %0d sums checked,",
             board.n_adds, board.n_queries, board.n_empty, board.n_checked);
    $display("with random gaps on both sides, a gap-free stretch and a long output hold-off.");
    if (board.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d mismatches found.", board.errors);
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/stsum_pkg.sv
rtl/stsum_ram.sv
rtl/stsum_accum.sv
rtl/stsum_seq.sv
rtl/segment_tree_range_sum.sv
tb/testbench.sv
